### rtl/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  // Storage default and fixed field widths.
  localparam int MAX_GRID_DIM_DEF = 32;
  localparam int POS_W      = 32;
  localparam int INV_W      = 24;
  localparam int SIZE_W     = 6;
  localparam int CHARGE_W   = 16;
  localparam int CELL_W     = 5;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Magnitude bits of a scaled grid point, one remainder step per bit.
  localparam int PT_MAG_W = 24;

  // Pipeline depth from issue to write-back of one cell update.
  localparam int SPREAD_LAT = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Z = 3'd5;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Weight codes: low side, middle and high side of the cloud.
  localparam logic [1:0] WGT_LO  = 2'd0;
  localparam logic [1:0] WGT_MID = 2'd1;
  localparam logic [1:0] WGT_HI  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       clr;
    logic       rd_issue;
    logic       rd_finish;
    logic       mul;
    logic       wgt;
    logic       mod_init;
    logic       mod_step;
    logic       mod_fix;
    logic       issue;
    logic [1:0] axis;
    logic [1:0] wstep;
    logic [1:0] ci;
    logic [1:0] cj;
    logic [1:0] ck;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic act_read;
    logic q_zero;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

### rtl/tcs_ram.sv
`default_nettype none

module tcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/tcs_ctrl.sv
`default_nettype none

module tcs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output      logic            busy,
  input  wire tcs_pkg::status_t status,
  output      tcs_pkg::cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CLEAR   = 9'b000000010,
    S_RD_ADDR = 9'b000000100,
    S_RD_DATA = 9'b000001000,
    S_MUL     = 9'b000010000,
    S_WGT     = 9'b000100000,
    S_MOD     = 9'b001000000,
    S_FIX     = 9'b010000000,
    S_SPREAD  = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] axis, axis_next;
  logic [1:0] ci, cj, ck, ci_next, cj_next, ck_next;
  logic       drain, drain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      axis  <= tcs_pkg::AXIS_X;
      ci    <= '0;
      cj    <= '0;
      ck    <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
      ci    <= ci_next;
      cj    <= cj_next;
      ck    <= ck_next;
      drain <= drain_next;
    end
  end

  // Sequencing: clear sweep, read and clear, or three axes then 27 cell updates.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    ci_next    = ci;
    cj_next    = cj;
    ck_next    = ck;
    drain_next = drain;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.wstep  = cnt[1:0];
    cmd.ci     = ci;
    cmd.cj     = cj;
    cmd.ck     = ck;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (status.act_read) begin
            state_next = S_RD_ADDR;
          end else if (!status.q_zero) begin
            state_next = S_MUL;
            axis_next  = tcs_pkg::AXIS_X;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_finish = 1'b1;
        state_next    = S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.wgt = 1'b1;
        if (cnt[1:0] == tcs_pkg::WGT_HI) begin
          cmd.mod_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_MOD;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == 5'(tcs_pkg::PT_MAG_W - 1)) begin
          state_next = S_FIX;
        end
        cnt_next = cnt + 5'd1;
      end
      S_FIX: begin
        cmd.mod_fix = 1'b1;
        if (axis == tcs_pkg::AXIS_Z) begin
          state_next = S_SPREAD;
          ci_next    = '0;
          cj_next    = '0;
          ck_next    = '0;
          drain_next = 1'b0;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_MUL;
        end
      end
      S_SPREAD: begin
        // Issue one cell a cycle, then let the pipeline drain.
        if (!drain) begin
          cmd.issue = 1'b1;
          if (ck != 2'd2) begin
            ck_next = ck + 2'd1;
          end else begin
            ck_next = '0;
            if (cj != 2'd2) begin
              cj_next = cj + 2'd1;
            end else begin
              cj_next = '0;
              if (ci != 2'd2) begin
                ci_next = ci + 2'd1;
              end else begin
                drain_next = 1'b1;
                cnt_next   = '0;
              end
            end
          end
        end else begin
          cnt_next = cnt + 5'd1;
          if (cnt == 5'(tcs_pkg::SPREAD_LAT - 1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/tcs_dp.sv
`default_nettype none

module tcs_dp #(
  parameter int MAX_GRID_DIM = tcs_pkg::MAX_GRID_DIM_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tcs_pkg::cmd_t                         cmd,
  output      tcs_pkg::status_t                      status,
  input  wire logic                                  cfg_we,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tcs_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  action,
  input  wire logic signed [tcs_pkg::POS_W-1:0]      pos_x,
  input  wire logic signed [tcs_pkg::POS_W-1:0]      pos_y,
  input  wire logic signed [tcs_pkg::POS_W-1:0]      pos_z,
  input  wire logic signed [tcs_pkg::CHARGE_W-1:0]   charge,
  input  wire logic [tcs_pkg::CELL_W-1:0]            cell_x,
  input  wire logic [tcs_pkg::CELL_W-1:0]            cell_y,
  input  wire logic [tcs_pkg::CELL_W-1:0]            cell_z,
  output      logic                                  valid,
  output      logic signed [tcs_pkg::VALUE_W-1:0]    cell_value
);

  localparam int DEPTH = MAX_GRID_DIM * MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_GRID_DIM);
  localparam int NW    = $clog2(MAX_GRID_DIM + 1);
  localparam int PW    = tcs_pkg::POS_W + tcs_pkg::INV_W + 1;

  // Configuration registers.
  logic [tcs_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic [tcs_pkg::INV_W-1:0]  inv_x, inv_y, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 6'd32;
      size_y <= 6'd32;
      size_z <= 6'd32;
      inv_x  <= 24'd65536;
      inv_y  <= 24'd65536;
      inv_z  <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        tcs_pkg::REG_GRID_SIZE_X:   size_x <= cfg_data[tcs_pkg::SIZE_W-1:0];
        tcs_pkg::REG_GRID_SIZE_Y:   size_y <= cfg_data[tcs_pkg::SIZE_W-1:0];
        tcs_pkg::REG_GRID_SIZE_Z:   size_z <= cfg_data[tcs_pkg::SIZE_W-1:0];
        tcs_pkg::REG_INV_SPACING_X: inv_x  <= cfg_data;
        tcs_pkg::REG_INV_SPACING_Y: inv_y  <= cfg_data;
        tcs_pkg::REG_INV_SPACING_Z: inv_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Size in use: clamped to the range from 4 to the storage dimension.
  function automatic logic [NW-1:0] used_size(input logic [tcs_pkg::SIZE_W-1:0] r);
    logic [7:0] r8;
    r8 = 8'(r);
    if (r8 < 8'd4) begin
      return NW'(4);
    end else if (r8 > 8'(MAX_GRID_DIM)) begin
      return NW'(MAX_GRID_DIM);
    end
    return NW'(r8);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] x, input logic [IW-1:0] y,
                                            input logic [IW-1:0] z);
    return AW'(x) * AW'(MAX_GRID_DIM * MAX_GRID_DIM) + AW'(y) * AW'(MAX_GRID_DIM) + AW'(z);
  endfunction

  // Neighbor index with a single periodic correction; b is already below n.
  function automatic logic [IW-1:0] nbr(input logic [IW-1:0] b, input logic [NW-1:0] n,
                                        input logic [1:0] i);
    logic [NW-1:0] bn;
    bn = NW'(b);
    if (i == 2'd0) begin
      return (bn == '0) ? IW'(n - NW'(1)) : IW'(bn - NW'(1));
    end else if (i == 2'd2) begin
      return (bn == n - NW'(1)) ? '0 : IW'(bn + NW'(1));
    end
    return b;
  endfunction

  logic [NW-1:0] n_x, n_y, n_z, n_sel;
  assign n_x = used_size(size_x);
  assign n_y = used_size(size_y);
  assign n_z = used_size(size_z);

  // Latched request.
  logic signed [tcs_pkg::POS_W-1:0]    px, py, pz;
  logic signed [tcs_pkg::CHARGE_W-1:0] q;
  logic [tcs_pkg::CELL_W-1:0]          rx, ry, rz;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      q  <= charge;
      rx <= cell_x;
      ry <= cell_y;
      rz <= cell_z;
    end
  end

  assign status.act_read = action;
  assign status.q_zero   = (charge == '0);

  // Axis selection.
  logic signed [tcs_pkg::POS_W-1:0] pos_sel;
  logic [tcs_pkg::INV_W-1:0]        inv_sel;

  always_comb begin
    case (cmd.axis)
      tcs_pkg::AXIS_X: begin
        pos_sel = px;
        inv_sel = inv_x;
        n_sel   = n_x;
      end
      tcs_pkg::AXIS_Y: begin
        pos_sel = py;
        inv_sel = inv_y;
        n_sel   = n_y;
      end
      default: begin
        pos_sel = pz;
        inv_sel = inv_z;
        n_sel   = n_z;
      end
    endcase
  end

  // Scaled position, exact at 2^-32.
  logic signed [PW-1:0] t_reg, tt;
  logic signed [24:0]   pt;
  logic [15:0]          u;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      t_reg <= pos_sel * $signed({1'b0, inv_sel});
    end
  end

  assign tt = t_reg + PW'(64'sd2147483648);
  assign pt = tt[PW-1:32];
  assign u  = tt[31:16];

  // Weight squares: one square per cycle.
  logic [16:0] sq_op;
  logic [33:0] sq, w_sum, mid_sum;
  logic [16:0] w_new;

  always_comb begin
    case (cmd.wstep)
      tcs_pkg::WGT_LO:  sq_op = 17'(17'd65536 - {1'b0, u});
      tcs_pkg::WGT_MID: sq_op = u[15] ? 17'({1'b0, u} - 17'd32768)
                                       : 17'(17'd32768 - {1'b0, u});
      default:          sq_op = {1'b0, u};
    endcase
  end

  assign sq      = sq_op * sq_op;
  assign w_sum   = sq + 34'd65536;
  assign mid_sum = 34'd6442450944 + 34'd65536 - {sq[32:0], 1'b0};
  assign w_new   = (cmd.wstep == tcs_pkg::WGT_MID) ? mid_sum[33:17] : w_sum[33:17];

  logic [16:0] wx [3];
  logic [16:0] wy [3];
  logic [16:0] wz [3];

  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      case (cmd.axis)
        tcs_pkg::AXIS_X: wx[cmd.wstep] <= w_new;
        tcs_pkg::AXIS_Y: wy[cmd.wstep] <= w_new;
        default:         wz[cmd.wstep] <= w_new;
      endcase
    end
  end

  // Remainder of the grid point by the size, one bit a cycle.
  logic [tcs_pkg::PT_MAG_W-1:0] mag;
  logic [NW-1:0]                rem;
  logic                         pt_neg;
  logic [24:0]                  pt_abs;
  logic [NW:0]                  r2;
  logic [NW-1:0]                r_fixed;
  logic [IW-1:0]                bx, by, bz;

  assign pt_abs  = pt[24] ? 25'(-pt) : 25'(pt);
  assign r2      = {rem, mag[tcs_pkg::PT_MAG_W-1]};
  assign r_fixed = (pt_neg && rem != '0) ? NW'(n_sel - rem) : rem;

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      mag    <= pt_abs[tcs_pkg::PT_MAG_W-1:0];
      rem    <= '0;
      pt_neg <= pt[24];
    end else if (cmd.mod_step) begin
      mag <= {mag[tcs_pkg::PT_MAG_W-2:0], 1'b0};
      rem <= (r2 >= {1'b0, n_sel}) ? NW'(r2 - {1'b0, n_sel}) : NW'(r2);
    end
    if (cmd.mod_fix) begin
      case (cmd.axis)
        tcs_pkg::AXIS_X: bx <= IW'(r_fixed);
        tcs_pkg::AXIS_Y: by <= IW'(r_fixed);
        default:         bz <= IW'(r_fixed);
      endcase
    end
  end

  // Cell update pipeline: weight product, charge product, read-modify-write.
  logic        v1, v2, v3;
  logic [33:0] p1, p2;
  logic [16:0] wz1;
  logic [AW-1:0] a1, a2, a3;
  logic signed [33:0] p3;
  logic [34:0] p1r, p2r;

  assign p1r = 35'(p1) + 35'd32768;
  assign p2r = 35'(p2) + 35'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p1  <= 34'(wx[cmd.ci]) * 34'(wy[cmd.cj]);
    wz1 <= wz[cmd.ck];
    a1  <= addr_of(nbr(bx, n_x, cmd.ci), nbr(by, n_y, cmd.cj), nbr(bz, n_z, cmd.ck));
    p2  <= 34'(p1r[32:16]) * 34'(wz1);
    a2  <= a1;
    p3  <= q * $signed({1'b0, p2r[32:16]});
    a3  <= a2;
  end

  // Grid memory and its port selection.
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr, clr_addr, rd_addr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic               rd_in_range;
  logic signed [33:0] p3r;
  logic signed [21:0] contrib;
  logic signed [32:0] acc;
  logic [31:0]        acc_sat;

  assign rd_in_range = (8'(rx) < 8'(MAX_GRID_DIM)) && (8'(ry) < 8'(MAX_GRID_DIM))
                     && (8'(rz) < 8'(MAX_GRID_DIM));
  assign rd_addr  = addr_of(IW'(rx), IW'(ry), IW'(rz));
  assign p3r      = p3 + 34'sd2048;
  assign contrib  = p3r[33:12];
  assign acc      = 33'($signed(ram_rdata)) + 33'(contrib);
  assign acc_sat  = (acc > 33'sd2147483647)  ? 32'h7fffffff :
                    (acc < -33'sd2147483648) ? 32'h80000000 : acc[31:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = a2;
    ram_we    = 1'b0;
    ram_waddr = a3;
    ram_wdata = acc_sat;
    if (cmd.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = rd_addr;
    end else if (v2) begin
      ram_re = 1'b1;
    end
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cmd.rd_finish) begin
      ram_we    = rd_in_range;
      ram_waddr = rd_addr;
      ram_wdata = '0;
    end else if (v3) begin
      ram_we = 1'b1;
    end
  end

  tcs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign status.clr_last = (clr_addr == AW'(DEPTH - 1));

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.rd_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_finish) begin
      cell_value <= rd_in_range ? $signed(ram_rdata) : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/tsc_charge_spread_3d.sv
`default_nettype none

// Channel   Handshake           Ports
// config    cfg_we              cfg_index, cfg_data
// request   start / busy        action, pos_x, pos_y, pos_z, charge, cell_x, cell_y, cell_z
// result    valid (one cycle)   cell_value
//
// A read request keeps busy high through the S_RD_ADDR and S_RD_DATA states, and
// its result is registered out of S_RD_DATA; a zero-charge spread leaves busy low.
// A spread keeps busy high through, per axis, a multiply, three weight squares,
// one remainder step per bit of the grid point and a fix-up, then 27 cell updates
// at one read-modify-write per cycle on the grid memory, then the pipeline drain.
// After reset the grid is swept to zero, all MAX_GRID_DIM^3 cells (32768 by
// default), with busy high; configuration writes are taken at all times.
// Results cannot be held off: each is shown for exactly one cycle.

module tsc_charge_spread_3d #(
  parameter int MAX_GRID_DIM = tcs_pkg::MAX_GRID_DIM_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic                                action,
  input  wire logic signed [tcs_pkg::POS_W-1:0]    pos_x,
  input  wire logic signed [tcs_pkg::POS_W-1:0]    pos_y,
  input  wire logic signed [tcs_pkg::POS_W-1:0]    pos_z,
  input  wire logic signed [tcs_pkg::CHARGE_W-1:0] charge,
  input  wire logic [tcs_pkg::CELL_W-1:0]          cell_x,
  input  wire logic [tcs_pkg::CELL_W-1:0]          cell_y,
  input  wire logic [tcs_pkg::CELL_W-1:0]          cell_z,
  output      logic                                valid,
  output      logic signed [tcs_pkg::VALUE_W-1:0]  cell_value
);

  tcs_pkg::cmd_t    cmd;
  tcs_pkg::status_t status;

  // Sequencer.
  tcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  // Arithmetic, configuration and grid storage.
  tcs_dp #(
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .charge    (charge),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cell_z    (cell_z),
    .valid     (valid),
    .cell_value(cell_value)
  );

endmodule

`default_nettype wire
